### design/vpt_pkg.sv
// ----------------------------------------------------------------------------
// vpt_pkg: shared types and constants of the value profile table
// sizes, status codes, register indexes and the value mapping helpers
// ----------------------------------------------------------------------------
package vpt_pkg;

	localparam int Records      = 64;
	localparam int CountersPerRecord = 4;
	localparam int MaxVals      = 8;
	localparam int PoolNodes    = 256;
	localparam int Sites        = Records * CountersPerRecord;
	localparam int Slots        = Sites * MaxVals;
	localparam int SiteW        = $clog2(Sites);
	localparam int SlotW        = $clog2(MaxVals);
	localparam int AddrW        = SiteW + SlotW;
	localparam int FillW        = $clog2(MaxVals + 1);
	localparam int NodeW        = 9;

	localparam logic [63:0] MemopKeep = 64'd8;
	localparam logic [63:0] MemopCap  = 64'd513;
	localparam logic [63:0] S64Min    = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		ST_IGNORED  = 3'd0,
		ST_MATCHED  = 3'd1,
		ST_NEW      = 3'd2,
		ST_REPLACED = 3'd3,
		ST_DECR     = 3'd4,
		ST_NO_NODES = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		KIND_PLAIN = 2'd0,
		KIND_RANGE = 2'd1,
		KIND_MEMOP = 2'd2,
		KIND_SPARE = 2'd3
	} kind_t;

	localparam logic [0:0] RegEnable    = 1'b0;
	localparam logic [0:0] RegNodeLimit = 1'b1;

	function automatic logic slt(input logic [63:0] a, input logic [63:0] b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic logic [63:0] map_range(input logic [63:0] v, input logic [63:0] start,
			input logic [63:0] last, input logic [63:0] cap);
		logic [63:0] r;
		if (cap != S64Min && !slt(v, cap))
			r = cap;
		else if (slt(v, start) || slt(last, v))
			r = last + 64'd1;
		else
			r = v;
		return r;
	endfunction

	// between 9 and 512 a power of two is kept, any other value maps to its top set bit (of bits 9..3) plus one
	function automatic logic [63:0] map_memop(input logic [63:0] v);
		logic [63:0] r;
		logic [9:0]  top;
		top = 10'd0;
		for (int i = 3; i < 10; i++)
			if (v[i])
				top = 10'(1 << i);
		if (v <= MemopKeep)
			r = v;
		else if (v >= MemopCap)
			r = MemopCap;
		else if ((v & (v - 64'd1)) == 64'd0)
			r = v;
		else
			r = {54'd0, top} + 64'd1;
		return r;
	endfunction

endpackage

### design/value_profile_top_n_table.sv
// ----------------------------------------------------------------------------
// value_profile_top_n_table: per-site top-n value counter with decaying minimum
// keeps up to eight value/count slots per site in two synchronous memories
// ----------------------------------------------------------------------------
// channel | dir | tdata / fields (low bit first)
// s_axis  | in  | kind[1:0] raw value[63:0] record[5:0] counter[1:0]
//         |     | range low, range high, cap (64 each), 6 pad bits, tdata 272 bits
// m_axis  | out | status[2:0] mapped_value[63:0] slot_index[2:0] slot_count[63:0]
// cfg     | in  | index 0 profiling_enabled, index 1 node_limit
//
// the scan ends at once when disabled or the site is empty, reads every filled
// slot with no match and stops at a match; the result passes the decide and done
// states into the held result, and the next request waits for idle and a free buffer
// reset clears fill valid bits, node counter and control registers; a fill entry reads
// zero until its valid bit is set, slots are read only below the site fill
// the result is held behind the output register; input stalls while it waits
module value_profile_top_n_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [271:0] s_axis_tdata,   // kind, raw value, record, counter,
	                                     // range low, range high, cap,
	                                     // 6 zero pad bits
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata,   // status, mapped_value, slot_index,
	                                     // slot_count, 2 zero pad bits
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [8:0]   cfg_data
);
	import vpt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MAP, S_SCAN, S_DECIDE, S_DONE
	} state_t;

	// slot memories, one read and one write port each
	logic [63:0] value_mem [Slots];
	logic [63:0] count_mem [Slots];
	logic [FillW-1:0] fill_mem [Sites];  // valid only where fill_vld_q is set

	logic               enable_q;
	logic [NodeW-1:0]   limit_q;
	logic [NodeW-1:0]   nodes_q;
	state_t             state_q;
	logic [265:0]       in_q;
	logic [63:0]        val_q;
	logic               site_ok_q;
	logic [SiteW-1:0]   site_q;
	logic [FillW-1:0]   fill_q;
	logic [FillW-1:0]   fill_rd_q;
	logic [Sites-1:0]   fill_vld_q;
	logic [FillW-1:0]   idx_q;          // slot being read this cycle
	logic               rd_pend_q;      // read data valid for slot rd_idx_q
	logic [SlotW-1:0]   rd_idx_q;
	logic [63:0]        rd_val_q, rd_cnt_q;
	logic               hit_q;
	logic [SlotW-1:0]   hit_idx_q, min_idx_q;
	logic [63:0]        hit_cnt_q, min_cnt_q;
	logic               res_full_q;     // result held for the output register
	logic [2:0]         res_status_q;
	logic [63:0]        res_val_q, res_cnt_q;
	logic [SlotW-1:0]   res_idx_q;
	logic               out_valid_q;
	logic [135:0]       out_data_q;

	logic [1:0]  in_kind;
	logic [5:0]  in_rec;
	logic [1:0]  in_ctr;
	logic [SiteW-1:0] in_site;
	logic [SiteW-1:0] fill_rd_addr;
	logic [NodeW-1:0] lim_eff;
	logic [AddrW-1:0] rd_addr;
	logic        wr_en;
	logic [AddrW-1:0] wr_addr;
	logic [63:0] wr_val, wr_cnt;
	logic        wr_val_en;

	assign in_kind = in_q[1:0];
	assign in_rec  = in_q[71:66];
	assign in_ctr  = in_q[73:72];
	assign in_site = SiteW'(in_rec * CountersPerRecord + in_ctr);
	// fill entry is read at the accepting edge, straight from the request
	assign fill_rd_addr = SiteW'(s_axis_tdata[71:66] * CountersPerRecord
		+ s_axis_tdata[73:72]);
	assign lim_eff = (limit_q < NodeW'(PoolNodes)) ? limit_q : NodeW'(PoolNodes);
	assign rd_addr = {site_q, idx_q[SlotW-1:0]};

	assign s_axis_tready = (state_q == S_IDLE) && !res_full_q;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// read port
	always_ff @(posedge clk) begin
		rd_val_q <= value_mem[rd_addr];
		rd_cnt_q <= count_mem[rd_addr];
	end

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			count_mem[wr_addr] <= wr_cnt;
			if (wr_val_en)
				value_mem[wr_addr] <= wr_val;
		end
	end

	// write decision, taken in the decide state
	logic [2:0] dec_status;
	logic [SlotW-1:0] dec_idx;
	logic [63:0] dec_cnt, dec_dcnt;
	logic dec_fill_inc;
	always_comb begin
		dec_status   = ST_IGNORED;
		dec_idx      = '0;
		dec_cnt      = '0;
		dec_fill_inc = 1'b0;
		wr_en        = 1'b0;
		wr_val_en    = 1'b0;
		wr_addr      = {site_q, dec_idx};
		wr_val       = val_q;
		wr_cnt       = '0;
		dec_dcnt     = min_cnt_q - 64'd1;
		if (state_q == S_DECIDE && site_ok_q) begin
			priority if (hit_q) begin
				dec_status = ST_MATCHED;
				dec_idx    = hit_idx_q;
				dec_cnt    = hit_cnt_q + 64'd1;
				wr_en      = 1'b1;
			end else if (fill_q >= FillW'(MaxVals)) begin
				dec_idx = min_idx_q;
				wr_en   = 1'b1;
				if (min_cnt_q == 64'd0 || dec_dcnt == 64'd0) begin
					dec_status = ST_REPLACED;
					dec_cnt    = 64'd1;
					wr_val_en  = 1'b1;
				end else begin
					dec_status = ST_DECR;
					dec_cnt    = dec_dcnt;
				end
			end else if (nodes_q >= lim_eff) begin
				dec_status = ST_NO_NODES;
			end else begin
				dec_status   = ST_NEW;
				dec_idx      = fill_q[SlotW-1:0];
				dec_cnt      = 64'd1;
				wr_en        = 1'b1;
				wr_val_en    = 1'b1;
				dec_fill_inc = 1'b1;
			end
		end
		wr_addr = {site_q, dec_idx};
		wr_cnt  = dec_cnt;
	end

	// fill memory, one read and one write port
	always_ff @(posedge clk) begin
		fill_rd_q <= fill_mem[fill_rd_addr];
		if (dec_fill_inc)
			fill_mem[site_q] <= fill_q + FillW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			enable_q    <= 1'b0;
			limit_q     <= NodeW'(256);
			nodes_q     <= '0;
			res_full_q  <= 1'b0;
			out_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
			hit_q       <= 1'b0;
			fill_vld_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					RegEnable:    enable_q <= cfg_data[0];
					RegNodeLimit: limit_q  <= cfg_data;
					default: ;
				endcase
			end

			// output register, refilled from the held result
			if (!out_valid_q || m_axis_tready) begin
				out_valid_q <= res_full_q;
				if (res_full_q) begin
					out_data_q <= {2'b00, res_cnt_q, res_idx_q, res_val_q, res_status_q};
					res_full_q <= 1'b0;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						in_q    <= s_axis_tdata[265:0];
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					unique case (kind_t'(in_kind))
						KIND_RANGE: val_q <= map_range(in_q[65:2], in_q[137:74],
							in_q[201:138], in_q[265:202]);
						KIND_MEMOP: val_q <= map_memop(in_q[65:2]);
						KIND_PLAIN, KIND_SPARE: val_q <= in_q[65:2];
						default: val_q <= in_q[65:2];
					endcase
					site_ok_q <= enable_q && (32'(in_rec) < Records)
						&& (32'(in_ctr) < CountersPerRecord);
					site_q    <= in_site;
					fill_q    <= fill_vld_q[in_site] ? fill_rd_q : '0;
					idx_q     <= '0;
					rd_pend_q <= 1'b0;
					hit_q     <= 1'b0;
					min_idx_q <= '0;
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					// compare the slot read last cycle while the next one is read
					rd_pend_q <= 1'b0;
					if (rd_pend_q && !hit_q) begin
						if (rd_val_q == val_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= rd_idx_q;
							hit_cnt_q <= rd_cnt_q;
						end
						if (rd_idx_q == '0 || rd_cnt_q < min_cnt_q) begin
							min_idx_q <= rd_idx_q;
							min_cnt_q <= rd_cnt_q;
						end
					end
					if (!site_ok_q || hit_q || idx_q >= fill_q
							|| idx_q >= FillW'(MaxVals)) begin
						if (!rd_pend_q || hit_q || !site_ok_q)
							state_q <= S_DECIDE;
					end else begin
						rd_pend_q <= 1'b1;
						rd_idx_q  <= idx_q[SlotW-1:0];
						idx_q     <= idx_q + FillW'(1);
					end
				end
				S_DECIDE: begin
					if (dec_fill_inc) begin
						fill_vld_q[site_q] <= 1'b1;
						nodes_q            <= nodes_q + NodeW'(1);
					end
					res_status_q <= dec_status;
					res_val_q    <= val_q;
					res_idx_q    <= dec_idx;
					res_cnt_q    <= dec_cnt;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					res_full_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result never waits while the output register is empty and free
	a_no_lost: assert property (@(posedge clk) disable iff (!arst_n)
		res_full_q && !out_valid_q |=> out_valid_q)
		else $error("held result not moved to output");
	// node count never passes the pool size
	a_nodes: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_q <= NodeW'(PoolNodes))
		else $error("node count beyond pool");
	// a new request is only taken with the result buffer free
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> !res_full_q && state_q == S_IDLE)
		else $error("request taken while busy");

endmodule
